@@ rtl/core/servo_slew_ramp_controller_defines.svh @@
// Assertion helpers shared by the servo slew controller.
`ifndef SERVO_SLEW_RAMP_CONTROLLER_DEFINES_SVH
`define SERVO_SLEW_RAMP_CONTROLLER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SSRC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("ssrc: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define SSRC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("ssrc: next-cycle check failed");

`endif

@@ rtl/core/ssrc_pkg.sv @@
`timescale 1ns / 1ps
package ssrc_pkg;

	localparam int NUM_LEGS_D       = 4;
	localparam int JOINTS_PER_LEG_D = 3;
	localparam int ANGLE_MAX_D      = 180;

	localparam int ANG_W   = 8;
	localparam int JSEL_W  = 5;
	localparam int MAX_RES = 12;
	localparam int CNT_W   = 4;

	localparam logic [ANG_W-1:0] POS_RESET = 8'd90;

	localparam logic [1:0] REQ_SET  = 2'd0;
	localparam logic [1:0] REQ_SNAP = 2'd1;
	localparam logic [1:0] REQ_TICK = 2'd2;

	localparam logic [2:0] REG_STEP  = 3'd0;
	localparam logic [2:0] REG_DB    = 3'd1;
	localparam logic [2:0] REG_PMIN  = 3'd2;
	localparam logic [2:0] REG_PMAX  = 3'd3;
	localparam logic [2:0] REG_OFFF  = 3'd4;
	localparam logic [2:0] REG_OFFR  = 3'd5;
	localparam logic [2:0] REG_CHMAP = 3'd6;

	localparam logic [7:0]  STEP_RESET  = 8'd2;
	localparam logic [7:0]  DB_RESET    = 8'd1;
	localparam logic [11:0] PMIN_RESET  = 12'd150;
	localparam logic [11:0] PMAX_RESET  = 12'd600;
	localparam logic [47:0] CHMAP_RESET = 48'hBA9876543210;

	typedef struct packed {
		logic [ANG_W-1:0] pos;
		logic [ANG_W-1:0] tgt;
		logic             act;
		logic             pend;
	} joint_t;

	typedef struct packed {
		logic             upd;
		logic [1:0]       req;
		logic [ANG_W-1:0] ang;
		logic [7:0]       step;
		logic [7:0]       db;
	} cmd_t;

	typedef struct packed {
		logic              wv;
		logic [JSEL_W-1:0] jsel;
		logic [3:0]        ld;
		logic              all;
		logic              last;
	} tok_t;

	typedef struct packed {
		logic        wv;
		logic [3:0]  ch;
		logic [11:0] pulse;
		logic [3:0]  jn;
		logic [3:0]  ld;
		logic        all;
		logic        last;
	} res_t;

	typedef struct packed {
		logic [11:0] pmin;
		logic [11:0] pmax;
		logic [47:0] offf;
		logic [47:0] offr;
		logic [47:0] chmap;
	} map_cfg_t;

endpackage

@@ rtl/core/ssrc_cell.sv @@
`timescale 1ns / 1ps
module ssrc_cell #(
	parameter int ANGLE_MAX = ssrc_pkg::ANGLE_MAX_D
) (
	input  logic            clk,
	input  logic            arst_n,
	input  ssrc_pkg::cmd_t  cmd,
	input  logic            hit,
	input  logic            shift,
	input  ssrc_pkg::joint_t nb,
	output ssrc_pkg::joint_t st,
	output ssrc_pkg::joint_t nxt
);

	localparam logic signed [9:0] AMAX_S = 10'(ANGLE_MAX);

	ssrc_pkg::joint_t st_q;
	logic [ssrc_pkg::ANG_W-1:0] ref_ang;
	logic signed [9:0] d;
	logic signed [9:0] sum;
	logic [8:0] dmag;
	logic near;
	logic [ssrc_pkg::ANG_W-1:0] stepped;

	assign st = st_q;

	// tick measures against the target, set/snap against the requested angle
	assign ref_ang = (cmd.req == ssrc_pkg::REQ_TICK) ? st_q.tgt : cmd.ang;
	assign d = $signed({2'b00, ref_ang}) - $signed({2'b00, st_q.pos});
	assign dmag = d[9] ? 9'(-d) : d[8:0];
	assign near = (dmag <= {1'b0, cmd.db});
	assign sum = d[9] ? ($signed({2'b00, st_q.pos}) - $signed({2'b00, cmd.step}))
		: ($signed({2'b00, st_q.pos}) + $signed({2'b00, cmd.step}));

	always_comb begin
		if (sum < 10'sd0) begin
			stepped = '0;
		end else if (sum > AMAX_S) begin
			stepped = AMAX_S[7:0];
		end else begin
			stepped = sum[7:0];
		end
	end

	always_comb begin
		nxt = st_q;
		if (cmd.upd) begin
			nxt.pend = 1'b0;
			unique case (cmd.req)
				ssrc_pkg::REQ_SET, ssrc_pkg::REQ_SNAP: begin
					if (hit) begin
						nxt.tgt = cmd.ang;
						if (cmd.req == ssrc_pkg::REQ_SNAP || near) begin
							nxt.pos  = cmd.ang;
							nxt.act  = 1'b0;
							nxt.pend = 1'b1;
						end else begin
							nxt.act = 1'b1;
						end
					end
				end
				ssrc_pkg::REQ_TICK: begin
					if (st_q.act) begin
						nxt.pend = 1'b1;
						if (near) begin
							nxt.pos = st_q.tgt;
							nxt.act = 1'b0;
						end else begin
							nxt.pos = stepped;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '{pos: ssrc_pkg::POS_RESET, tgt: ssrc_pkg::POS_RESET,
				act: 1'b0, pend: 1'b0};
		end else if (cmd.upd) begin
			st_q <= nxt;
		end else if (shift) begin
			st_q <= nb;
		end
	end

endmodule

@@ rtl/core/ssrc_pulse_map.sv @@
`timescale 1ns / 1ps
module ssrc_pulse_map #(
	parameter int ANGLE_MAX = ssrc_pkg::ANGLE_MAX_D
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       launch,
	input  ssrc_pkg::tok_t             tok,
	input  logic [ssrc_pkg::ANG_W-1:0] pos,
	input  ssrc_pkg::map_cfg_t         cfg,
	input  logic                       out_ready,
	output logic                       busy,
	output logic                       out_valid,
	output ssrc_pkg::res_t             res
);

	localparam int SH = 20;
	localparam logic [13:0] RECIP = 14'((1 << SH) / ANGLE_MAX);
	localparam logic signed [9:0] AMAX_S = 10'(ANGLE_MAX);
	localparam logic [19:0] AMAX_W = 20'(ANGLE_MAX);

	logic [5:0][7:0]  offf_b;
	logic [5:0][7:0]  offr_b;
	logic [11:0][3:0] ch_b;
	logic [7:0] off;
	logic [3:0] ch;
	logic [ssrc_pkg::JSEL_W-1:0] jr;
	logic signed [9:0] asum;
	logic [7:0] a;
	ssrc_pkg::res_t r_in;

	logic v_s1, v_s2, v_s3, out_v_q;
	logic [7:0] a_s1;
	ssrc_pkg::res_t r_s1, r_s2, r_s3, out_q;
	logic [19:0] mag_s2, mag_s3;
	logic neg_s2, neg_s3;
	logic [11:0] q0_s3;

	logic signed [12:0] span;
	logic signed [21:0] prod;
	logic [21:0] magw;
	logic [33:0] qm;
	logic [19:0] qa;
	logic [19:0] rem;
	logic [12:0] q;
	logic [12:0] pulse13;
	ssrc_pkg::res_t r_out;

	assign offf_b = cfg.offf;
	assign offr_b = cfg.offr;
	assign ch_b   = cfg.chmap;
	assign jr     = tok.jsel - ssrc_pkg::JSEL_W'(6);

	// only the first twelve joints have an offset and a channel
	always_comb begin
		off = '0;
		ch  = '0;
		if (tok.jsel < ssrc_pkg::JSEL_W'(6)) begin
			off = offf_b[tok.jsel[2:0]];
		end else if (tok.jsel < ssrc_pkg::JSEL_W'(12)) begin
			off = offr_b[jr[2:0]];
		end
		if (tok.jsel < ssrc_pkg::JSEL_W'(12)) begin
			ch = ch_b[tok.jsel[3:0]];
		end
	end

	assign asum = $signed({2'b00, pos}) + $signed({{2{off[7]}}, off});

	always_comb begin
		if (asum < 10'sd0) begin
			a = '0;
		end else if (asum > AMAX_S) begin
			a = AMAX_S[7:0];
		end else begin
			a = asum[7:0];
		end
	end

	always_comb begin
		r_in.wv    = tok.wv;
		r_in.ch    = tok.wv ? ch : 4'd0;
		r_in.pulse = '0;
		r_in.jn    = tok.wv ? tok.jsel[3:0] : 4'd0;
		r_in.ld    = tok.ld;
		r_in.all   = tok.all;
		r_in.last  = tok.last;
	end

	assign span = $signed({1'b0, cfg.pmax}) - $signed({1'b0, cfg.pmin});
	assign prod = $signed({1'b0, a_s1}) * span;
	assign magw = prod[21] ? 22'(-prod) : 22'(prod);

	// quotient by reciprocal; estimate is at most one low
	assign qm = 34'(mag_s2) * 34'(RECIP);

	assign qa  = 20'(q0_s3) * AMAX_W;
	assign rem = mag_s3 - qa;
	assign q   = {1'b0, q0_s3} + 13'(rem >= AMAX_W);
	assign pulse13 = neg_s3 ? ({1'b0, cfg.pmin} - q) : ({1'b0, cfg.pmin} + q);

	always_comb begin
		r_out = r_s3;
		r_out.pulse = r_s3.wv ? pulse13[11:0] : 12'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			v_s1 <= launch;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			if (v_s3) begin
				out_v_q <= 1'b1;
			end else if (out_ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (launch) begin
			a_s1 <= a;
			r_s1 <= r_in;
		end
		if (v_s1) begin
			mag_s2 <= magw[19:0];
			neg_s2 <= prod[21];
			r_s2   <= r_s1;
		end
		if (v_s2) begin
			q0_s3  <= qm[SH+11:SH];
			mag_s3 <= mag_s2;
			neg_s3 <= neg_s2;
			r_s3   <= r_s2;
		end
		if (v_s3) begin
			out_q <= r_out;
		end
	end

	assign busy      = v_s1 | v_s2 | v_s3;
	assign out_valid = out_v_q;
	assign res       = out_q;

endmodule

@@ rtl/core/servo_slew_ramp_controller.sv @@
`timescale 1ns / 1ps
`include "servo_slew_ramp_controller_defines.svh"
// Slew-rate limiter for NUM_LEGS x JOINTS_PER_LEG servo joints. Each joint lives in one cell
// of a ring; a request updates all cells in its accept cycle, then the ring rotates once past
// the head cell and every joint the request wrote is sent through a four-stage pulse mapper
// (offset and clamp, multiply by span, reciprocal quotient, correction and add of pulse_min).
// One write is in flight at a time, and a request sends at most 12 writes; a request with no
// write yields one result with write_valid low. A new request is taken as soon as the ring is
// home again, while the previous results may still be draining. Register map (64-bit APB, 8
// bytes apart): step_size, deadband, pulse_min, pulse_max, offsets_front, offsets_rear,
// channel_map.
module servo_slew_ramp_controller #(
	parameter int NUM_LEGS       = ssrc_pkg::NUM_LEGS_D,
	parameter int JOINTS_PER_LEG = ssrc_pkg::JOINTS_PER_LEG_D,
	parameter int ANGLE_MAX      = ssrc_pkg::ANGLE_MAX_D
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // leg[1:0], joint[3:2], angle[14:4]
	input  logic [1:0]  s_tuser,   // req_type[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	// write_valid[0], pwm_channel[4:1], pulse_ticks[16:5], joint_number[20:17],
	// legs_done[24:21], all_done[25]
	output logic [31:0] m_tdata,
	output logic        m_tlast,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [5:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready
);

	localparam int NJ = NUM_LEGS * JOINTS_PER_LEG;
	localparam int IW = (NJ > 1) ? $clog2(NJ) : 1;
	localparam int JW = ssrc_pkg::JSEL_W;
	localparam int CW = ssrc_pkg::CNT_W;

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_SCAN  = 3'b010,
		ST_EMPTY = 3'b100
	} state_t;

	state_t state_q;
	logic [IW-1:0] cnt_q;
	logic [CW-1:0] emit_q;
	logic [3:0] ld_q;
	logic all_q;

	logic [7:0]  step_q, db_q;
	logic [11:0] pmin_q, pmax_q;
	logic [47:0] offf_q, offr_q, chmap_q;

	logic cfg_wr;
	logic [2:0] cfg_idx;

	logic acc;
	logic signed [10:0] ang_raw;
	logic [ssrc_pkg::ANG_W-1:0] ang_c;
	logic addr_ok;
	logic [JW-1:0] j_req;
	logic [NJ-1:0] hit;
	ssrc_pkg::cmd_t cmd;

	ssrc_pkg::joint_t st [NJ];
	ssrc_pkg::joint_t nxt [NJ];
	ssrc_pkg::joint_t nb [NJ];
	logic shift;

	logic [NUM_LEGS-1:0] leg_busy;
	logic [3:0] ld_nxt;
	logic all_nxt;
	logic any_wr, rest_pend, any_pend;

	logic launch, launch_ok, head_ok, busy;
	ssrc_pkg::tok_t tok;
	ssrc_pkg::map_cfg_t mcfg;
	ssrc_pkg::res_t res;

	// configuration port
	assign pready  = 1'b1;
	assign cfg_wr  = psel & penable & pwrite & pready;
	assign cfg_idx = paddr[5:3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q  <= ssrc_pkg::STEP_RESET;
			db_q    <= ssrc_pkg::DB_RESET;
			pmin_q  <= ssrc_pkg::PMIN_RESET;
			pmax_q  <= ssrc_pkg::PMAX_RESET;
			offf_q  <= '0;
			offr_q  <= '0;
			chmap_q <= ssrc_pkg::CHMAP_RESET;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				ssrc_pkg::REG_STEP:  step_q  <= pwdata[7:0];
				ssrc_pkg::REG_DB:    db_q    <= pwdata[7:0];
				ssrc_pkg::REG_PMIN:  pmin_q  <= pwdata[11:0];
				ssrc_pkg::REG_PMAX:  pmax_q  <= pwdata[11:0];
				ssrc_pkg::REG_OFFF:  offf_q  <= pwdata[47:0];
				ssrc_pkg::REG_OFFR:  offr_q  <= pwdata[47:0];
				ssrc_pkg::REG_CHMAP: chmap_q <= pwdata[47:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (cfg_idx)
			ssrc_pkg::REG_STEP:  prdata = {56'd0, step_q};
			ssrc_pkg::REG_DB:    prdata = {56'd0, db_q};
			ssrc_pkg::REG_PMIN:  prdata = {52'd0, pmin_q};
			ssrc_pkg::REG_PMAX:  prdata = {52'd0, pmax_q};
			ssrc_pkg::REG_OFFF:  prdata = {16'd0, offf_q};
			ssrc_pkg::REG_OFFR:  prdata = {16'd0, offr_q};
			ssrc_pkg::REG_CHMAP: prdata = {16'd0, chmap_q};
			default:             prdata = '0;
		endcase
	end

	// request decode
	assign s_tready = (state_q == ST_IDLE);
	assign acc      = s_tvalid & s_tready;
	assign ang_raw  = $signed(s_tdata[14:4]);

	always_comb begin
		if (ang_raw < 11'sd0) begin
			ang_c = '0;
		end else if (ang_raw > $signed(11'(ANGLE_MAX))) begin
			ang_c = 8'(ANGLE_MAX);
		end else begin
			ang_c = ang_raw[7:0];
		end
	end

	assign addr_ok = (32'(s_tdata[1:0]) < NUM_LEGS) && (32'(s_tdata[3:2]) < JOINTS_PER_LEG);
	assign j_req   = JW'(s_tdata[1:0]) * JW'(JOINTS_PER_LEG) + JW'(s_tdata[3:2]);

	assign cmd.upd  = acc;
	assign cmd.req  = s_tuser;
	assign cmd.ang  = ang_c;
	assign cmd.step = (step_q == 8'd0) ? 8'd1 : step_q;
	assign cmd.db   = db_q;

	// ring of joint cells; the head cell drops its pending mark as it wraps
	always_comb begin
		for (int i = 0; i < NJ - 1; i++) begin
			nb[i] = st[i+1];
		end
		nb[NJ-1] = st[0];
		nb[NJ-1].pend = 1'b0;
	end

	for (genvar i = 0; i < NJ; i++) begin : g_cell
		assign hit[i] = addr_ok && (j_req == JW'(i));
		ssrc_cell #(
			.ANGLE_MAX(ANGLE_MAX)
		) u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.cmd   (cmd),
			.hit   (hit[i]),
			.shift (shift),
			.nb    (nb[i]),
			.st    (st[i]),
			.nxt   (nxt[i])
		);
	end

	// done flags from the state after the whole request
	always_comb begin
		ld_nxt  = '0;
		all_nxt = 1'b1;
		for (int l = 0; l < NUM_LEGS; l++) begin
			leg_busy[l] = 1'b0;
			for (int i = 0; i < JOINTS_PER_LEG; i++) begin
				leg_busy[l] = leg_busy[l] | nxt[l*JOINTS_PER_LEG+i].act;
			end
			if (l < 4) begin
				ld_nxt[2'(l)] = !leg_busy[l];
			end
			if (leg_busy[l]) begin
				all_nxt = 1'b0;
			end
		end
	end

	always_comb begin
		any_wr    = 1'b0;
		any_pend  = 1'b0;
		rest_pend = 1'b0;
		for (int i = 0; i < NJ; i++) begin
			any_wr   = any_wr | nxt[i].pend;
			any_pend = any_pend | st[i].pend;
		end
		for (int i = 1; i < NJ; i++) begin
			rest_pend = rest_pend | st[i].pend;
		end
	end

	// sequencer
	assign launch_ok = !busy && (!m_tvalid || m_tready);
	assign head_ok   = st[0].pend && (emit_q < CW'(ssrc_pkg::MAX_RES));

	always_comb begin
		launch   = 1'b0;
		shift    = 1'b0;
		tok.wv   = 1'b0;
		tok.jsel = '0;
		tok.ld   = ld_q;
		tok.all  = all_q;
		tok.last = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
			end
			ST_SCAN: begin
				tok.wv   = 1'b1;
				tok.jsel = JW'(cnt_q);
				tok.last = (emit_q == CW'(ssrc_pkg::MAX_RES - 1)) || !rest_pend;
				if (head_ok) begin
					launch = launch_ok;
					shift  = launch_ok;
				end else begin
					shift = 1'b1;
				end
			end
			ST_EMPTY: begin
				launch = launch_ok;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			emit_q  <= '0;
			ld_q    <= '0;
			all_q   <= 1'b1;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (acc) begin
						ld_q    <= ld_nxt;
						all_q   <= all_nxt;
						cnt_q   <= '0;
						emit_q  <= '0;
						state_q <= any_wr ? ST_SCAN : ST_EMPTY;
					end
				end
				ST_SCAN: begin
					if (launch) begin
						emit_q <= emit_q + CW'(1);
					end
					if (shift) begin
						if (cnt_q == IW'(NJ - 1)) begin
							cnt_q   <= '0;
							state_q <= ST_IDLE;
						end else begin
							cnt_q <= cnt_q + IW'(1);
						end
					end
				end
				ST_EMPTY: begin
					if (launch) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign mcfg.pmin  = pmin_q;
	assign mcfg.pmax  = pmax_q;
	assign mcfg.offf  = offf_q;
	assign mcfg.offr  = offr_q;
	assign mcfg.chmap = chmap_q;

	ssrc_pulse_map #(
		.ANGLE_MAX(ANGLE_MAX)
	) u_map (
		.clk      (clk),
		.arst_n   (arst_n),
		.launch   (launch),
		.tok      (tok),
		.pos      (st[0].pos),
		.cfg      (mcfg),
		.out_ready(m_tready),
		.busy     (busy),
		.out_valid(m_tvalid),
		.res      (res)
	);

	assign m_tdata = {6'd0, res.all, res.ld, res.jn, res.pulse, res.ch, res.wv};
	assign m_tlast = res.last;

	// ring must be drained of pending writes whenever a new request can enter
	`SSRC_ASSERT_NOW(a_idle_no_pend, clk, arst_n, state_q == ST_IDLE, !any_pend)
	// the mapper carries a single write at a time
	`SSRC_ASSERT_NEXT(a_one_in_flight, clk, arst_n, launch, !launch)
	// a result without a write is always the only, hence last, one of its request
	`SSRC_ASSERT_NOW(a_nowrite_last, clk, arst_n, m_tvalid && !m_tdata[0], m_tlast)

endmodule
